/* rtl/core/sorted_priority_job_queue_macros.svh */
// Assertion macros for the port-level job queue checker.
`ifndef SORTED_PRIORITY_JOB_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_JOB_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SPJQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SPJQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/spjq_pkg.sv */
// Shared types and constants for the sorted priority job queue.
`timescale 1ns / 1ps
`default_nettype none

package spjq_pkg;

  localparam int QUEUE_DEPTH_DEF = 8;

  localparam int PRIO_W   = 4;
  localparam int JOB_ID_W = 17;
  localparam int PROD_W   = 8;
  localparam int PID_W    = 22;
  localparam int CTIME_W  = 4;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 4;
  localparam int COUNT_W  = 16;

  localparam logic [COUNT_W-1:0] LIMIT_RST = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_LIMIT = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    MODE_INSERT = 1'b0,
    MODE_POP    = 1'b1
  } mode_t;

  // 55-bit entry, priority in the top bits
  typedef struct packed {
    logic [PRIO_W-1:0]   prio;
    logic [JOB_ID_W-1:0] job_id;
    logic [PROD_W-1:0]   producer;
    logic [PID_W-1:0]    pid;
    logic [CTIME_W-1:0]  ctime;
  } job_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture the accepted request
    logic exec;   // run the operation and load the result register
  } ctl_cmd_t;

endpackage

`default_nettype wire

/* rtl/core/sorted_priority_job_queue.sv */
// Top level of the sorted priority job queue.
`timescale 1ns / 1ps
`default_nettype none

// Priority job queue of QUEUE_DEPTH entries kept sorted highest priority
// first; equal priorities leave in arrival order. in_mode 0 inserts the job
// on the in_ fields, 1 pops the head. Every transaction returns exactly one
// result: out_status (done, full, empty or job limit reached), the popped job
// (all zero unless a pop succeeded), the occupancy afterward (mod 16) and the
// saturating count of popped jobs. Once that count reaches cfg_job_limit
// (reset 65535) every request is refused with state unchanged. Each request
// is first registered, then executed: a parallel compare of all entries and
// a one-place shift of the entry register. A new request is taken only after
// the last has executed, which needs a free result register. A result held
// by out_stall blocks the next request only once it reaches execute.
// Write cfg_job_limit only with no transaction outstanding.
module sorted_priority_job_queue #(
  parameter int QUEUE_DEPTH = spjq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_mode,
  input  logic [spjq_pkg::PRIO_W-1:0]     in_priority_req,
  input  logic [spjq_pkg::JOB_ID_W-1:0]   in_job_id,
  input  logic [spjq_pkg::PROD_W-1:0]     in_producer_number,
  input  logic [spjq_pkg::PID_W-1:0]      in_process_id,
  input  logic [spjq_pkg::CTIME_W-1:0]    in_compute_time,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [spjq_pkg::STATUS_W-1:0]   out_status,
  output logic [spjq_pkg::PRIO_W-1:0]     out_priority,
  output logic [spjq_pkg::JOB_ID_W-1:0]   out_job_id,
  output logic [spjq_pkg::PROD_W-1:0]     out_producer_number,
  output logic [spjq_pkg::PID_W-1:0]      out_process_id,
  output logic [spjq_pkg::CTIME_W-1:0]    out_compute_time,
  output logic [spjq_pkg::OCC_W-1:0]      out_occupancy,
  output logic [spjq_pkg::COUNT_W-1:0]    out_consumed_count,
  input  logic                            cfg_we,
  input  logic [spjq_pkg::COUNT_W-1:0]    cfg_job_limit
);
  import spjq_pkg::*;

  ctl_cmd_t cmd;
  job_t     req_job;
  job_t     res_job;
  status_t  res_status;

  assign req_job.prio     = in_priority_req;
  assign req_job.job_id   = in_job_id;
  assign req_job.producer = in_producer_number;
  assign req_job.pid      = in_process_id;
  assign req_job.ctime    = in_compute_time;

  spjq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  spjq_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .req_mode      (in_mode),
    .req_job       (req_job),
    .cfg_we        (cfg_we),
    .cfg_job_limit (cfg_job_limit),
    .res_status    (res_status),
    .res_job       (res_job),
    .res_occupancy (out_occupancy),
    .res_consumed  (out_consumed_count)
  );

  assign out_status          = res_status;
  assign out_priority        = res_job.prio;
  assign out_job_id          = res_job.job_id;
  assign out_producer_number = res_job.producer;
  assign out_process_id      = res_job.pid;
  assign out_compute_time    = res_job.ctime;

endmodule

`default_nettype wire

/* rtl/core/spjq_ctrl.sv */
// Control state machine: request handshake, execute slot and result valid.
`timescale 1ns / 1ps
`default_nettype none

module spjq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output spjq_pkg::ctl_cmd_t cmd
);
  import spjq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  // result register is free if empty or being taken this cycle
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd.load      = 1'b0;
    cmd.exec      = 1'b0;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          cmd.exec      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

/* rtl/core/spjq_dpath.sv */
// Datapath: sorted entry shift register, counters, limit register, result register.
`timescale 1ns / 1ps
`default_nettype none

module spjq_dpath #(
  parameter int QUEUE_DEPTH = spjq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  spjq_pkg::ctl_cmd_t             cmd,
  input  logic                           req_mode,
  input  spjq_pkg::job_t                 req_job,
  input  logic                           cfg_we,
  input  logic [spjq_pkg::COUNT_W-1:0]   cfg_job_limit,
  output spjq_pkg::status_t              res_status,
  output spjq_pkg::job_t                 res_job,
  output logic [spjq_pkg::OCC_W-1:0]     res_occupancy,
  output logic [spjq_pkg::COUNT_W-1:0]   res_consumed
);
  import spjq_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // request capture
  mode_t                mode_r;
  job_t                 req_r;

  logic [COUNT_W-1:0]   job_limit_r;
  logic [COUNT_W-1:0]   consumed_r, consumed_nxt;
  logic [QUEUE_DEPTH-1:0] valid_r, valid_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  job_t                 ent_r   [QUEUE_DEPTH];
  job_t                 ent_nxt [QUEUE_DEPTH];

  status_t              out_status_r;
  job_t                 out_job_r;
  logic [OCC_W-1:0]     out_occ_r;
  logic [COUNT_W-1:0]   out_cons_r;

  logic                 limit_hit, full, empty, do_ins, do_pop;
  status_t              status;
  logic [QUEUE_DEPTH-1:0] gt, gt_sh, first;
  job_t                 prev_ent [QUEUE_DEPTH];
  job_t                 next_ent [QUEUE_DEPTH];

  assign limit_hit = (consumed_r >= job_limit_r);
  assign full      = valid_r[QUEUE_DEPTH-1];
  assign empty     = !valid_r[0];

  // Queue is sorted and valid entries form a prefix, so gt is a thermometer
  // code: its lowest set bit is the insert slot, set bits at and behind it shift.
  genvar g;
  for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cmp
    assign gt[g] = !valid_r[g] || (req_r.prio > ent_r[g].prio);
    if (g == 0) begin : g_head
      assign prev_ent[g] = req_r;
    end else begin : g_body
      assign prev_ent[g] = ent_r[g-1];
    end
    if (g == QUEUE_DEPTH - 1) begin : g_tail
      assign next_ent[g] = '0;
    end else begin : g_mid
      assign next_ent[g] = ent_r[g+1];
    end
  end

  assign gt_sh = {gt[QUEUE_DEPTH-2:0], 1'b0};
  assign first = gt & ~gt_sh;

  always_comb begin
    priority if (limit_hit) begin
      status = ST_LIMIT;
    end else if (mode_r == MODE_INSERT) begin
      status = full ? ST_FULL : ST_DONE;
    end else begin
      status = empty ? ST_EMPTY : ST_DONE;
    end
  end

  assign do_ins = cmd.exec && !limit_hit && (mode_r == MODE_INSERT) && !full;
  assign do_pop = cmd.exec && !limit_hit && (mode_r == MODE_POP) && !empty;

  always_comb begin
    valid_nxt    = valid_r;
    cnt_nxt      = cnt_r;
    consumed_nxt = consumed_r;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ent_nxt[i] = ent_r[i];
    end
    if (do_ins) begin
      valid_nxt = {valid_r[QUEUE_DEPTH-2:0], 1'b1};
      cnt_nxt   = cnt_r + 1'b1;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (first[i]) begin
          ent_nxt[i] = req_r;
        end else if (gt[i]) begin
          ent_nxt[i] = prev_ent[i];
        end
      end
    end else if (do_pop) begin
      valid_nxt = {1'b0, valid_r[QUEUE_DEPTH-1:1]};
      cnt_nxt   = cnt_r - 1'b1;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        ent_nxt[i] = next_ent[i];
      end
      if (consumed_r != COUNT_MAX) begin
        consumed_nxt = consumed_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_limit_r <= LIMIT_RST;
      consumed_r  <= '0;
      valid_r     <= '0;
      cnt_r       <= '0;
    end else begin
      if (cfg_we) begin
        job_limit_r <= cfg_job_limit;
      end
      consumed_r <= consumed_nxt;
      valid_r    <= valid_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ent_r[i] <= ent_nxt[i];
    end
    if (cmd.load) begin
      mode_r <= mode_t'(req_mode);
      req_r  <= req_job;
    end
    if (cmd.exec) begin
      out_status_r <= status;
      out_job_r    <= do_pop ? ent_r[0] : '0;
      out_occ_r    <= OCC_W'(cnt_nxt);
      out_cons_r   <= consumed_nxt;
    end
  end

  assign res_status    = out_status_r;
  assign res_job       = out_job_r;
  assign res_occupancy = out_occ_r;
  assign res_consumed  = out_cons_r;

endmodule

`default_nettype wire

/* rtl/core/spjq_checker.sv */
// Port-level assertion checker for the job queue, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_priority_job_queue_macros.svh"

module spjq_checker #(
  parameter int QUEUE_DEPTH = spjq_pkg::QUEUE_DEPTH_DEF
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [spjq_pkg::STATUS_W-1:0]   out_status,
  input logic [spjq_pkg::PRIO_W-1:0]     out_priority,
  input logic [spjq_pkg::JOB_ID_W-1:0]   out_job_id,
  input logic [spjq_pkg::PROD_W-1:0]     out_producer_number,
  input logic [spjq_pkg::PID_W-1:0]      out_process_id,
  input logic [spjq_pkg::CTIME_W-1:0]    out_compute_time,
  input logic [spjq_pkg::OCC_W-1:0]      out_occupancy
);
  import spjq_pkg::*;

  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(QUEUE_DEPTH);

  // a held transaction keeps its result
  `SPJQ_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_status) && $stable(out_job_id) && $stable(out_occupancy), "spjq: stalled result changed")

  // only a successful pop carries a job
  `SPJQ_ASSERT_IMP(a_refused_zero, out_valid && out_status != ST_DONE, out_priority == '0 && out_job_id == '0 && out_producer_number == '0 && out_process_id == '0 && out_compute_time == '0, "spjq: refused transaction carries job data")

  `SPJQ_ASSERT_IMP(a_full_occ, out_valid && out_status == ST_FULL, out_occupancy == OCC_FULL, "spjq: full reported below depth")

  `SPJQ_ASSERT_IMP(a_empty_occ, out_valid && out_status == ST_EMPTY, out_occupancy == '0, "spjq: empty reported with entries held")

endmodule

bind sorted_priority_job_queue spjq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_spjq_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_status          (out_status),
  .out_priority        (out_priority),
  .out_job_id          (out_job_id),
  .out_producer_number (out_producer_number),
  .out_process_id      (out_process_id),
  .out_compute_time    (out_compute_time),
  .out_occupancy       (out_occupancy)
);

`default_nettype wire

/* test/spjq_job_checker.sv */
// Result checker for the sorted priority job queue: mirrors the queue and compares each result.
`timescale 1ns / 1ps

module spjq_job_checker
  import spjq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic                in_mode,
  input  logic [PRIO_W-1:0]   in_priority_req,
  input  logic [JOB_ID_W-1:0] in_job_id,
  input  logic [PROD_W-1:0]   in_producer_number,
  input  logic [PID_W-1:0]    in_process_id,
  input  logic [CTIME_W-1:0]  in_compute_time,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [STATUS_W-1:0] out_status,
  input  logic [PRIO_W-1:0]   out_priority,
  input  logic [JOB_ID_W-1:0] out_job_id,
  input  logic [PROD_W-1:0]   out_producer_number,
  input  logic [PID_W-1:0]    out_process_id,
  input  logic [CTIME_W-1:0]  out_compute_time,
  input  logic [OCC_W-1:0]    out_occupancy,
  input  logic [COUNT_W-1:0]  out_consumed_count,
  input  logic                cfg_we,
  input  logic [COUNT_W-1:0]  cfg_job_limit,
  output int                  fail_count,
  output int                  outstanding,
  output logic [COUNT_W-1:0]  consumed_jobs
);

  typedef struct packed {
    status_t             status;
    job_t                job;
    logic [OCC_W-1:0]    occupancy;
    logic [COUNT_W-1:0]  consumed;
  } queue_result_t;

  job_t                slots [QUEUE_DEPTH];
  logic                slot_used [QUEUE_DEPTH];
  logic [COUNT_W-1:0]  consumed_total;
  logic [COUNT_W-1:0]  limit_reg;
  queue_result_t       pending_results [$];
  int                  mismatches = 0;

  initial begin
    outstanding = 0;
    consumed_jobs = '0;
  end

  assign fail_count = mismatches;

  // One insert or pop applied to the mirrored queue.
  function automatic queue_result_t apply_request(mode_t mode, job_t job);
    queue_result_t res;
    int pos;
    int held;
    int i;
    res = '0;
    res.status = ST_DONE;
    if (consumed_total >= limit_reg) begin
      res.status = ST_LIMIT;
    end else if (mode == MODE_INSERT) begin
      if (slot_used[QUEUE_DEPTH-1]) begin
        res.status = ST_FULL;
      end else begin
        // first empty slot or first entry of strictly lower priority
        pos = QUEUE_DEPTH - 1;
        for (i = QUEUE_DEPTH - 1; i >= 0; i--)
          if (!slot_used[i] || job.prio > slots[i].prio) pos = i;
        for (i = QUEUE_DEPTH - 1; i > pos; i--) begin
          slots[i] = slots[i-1];
          slot_used[i] = slot_used[i-1];
        end
        slots[pos] = job;
        slot_used[pos] = 1'b1;
      end
    end else begin
      if (!slot_used[0]) begin
        res.status = ST_EMPTY;
      end else begin
        res.job = slots[0];
        for (i = 0; i < QUEUE_DEPTH - 1; i++) begin
          slots[i] = slots[i+1];
          slot_used[i] = slot_used[i+1];
        end
        slots[QUEUE_DEPTH-1] = '0;
        slot_used[QUEUE_DEPTH-1] = 1'b0;
        if (consumed_total != COUNT_MAX) consumed_total++;
      end
    end
    held = 0;
    for (i = 0; i < QUEUE_DEPTH; i++)
      if (slot_used[i]) held++;
    res.occupancy = OCC_W'(held);
    res.consumed = consumed_total;
    return res;
  endfunction

  task automatic check_field(string field, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : track
    queue_result_t want;
    queue_result_t predicted;
    job_t req;
    int i;
    if (!rst_n) begin
      for (i = 0; i < QUEUE_DEPTH; i++) begin
        slots[i] = '0;
        slot_used[i] = 1'b0;
      end
      consumed_total = '0;
      limit_reg = LIMIT_RST;
      pending_results.delete();
    end else begin
      if (cfg_we) limit_reg = cfg_job_limit;
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: expected no result, actual status %0d job_id %0d",
                   $time, out_status, out_job_id);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("out_status", want.status, out_status);
          check_field("out_priority", want.job.prio, out_priority);
          check_field("out_job_id", want.job.job_id, out_job_id);
          check_field("out_producer_number", want.job.producer, out_producer_number);
          check_field("out_process_id", want.job.pid, out_process_id);
          check_field("out_compute_time", want.job.ctime, out_compute_time);
          check_field("out_occupancy", want.occupancy, out_occupancy);
          check_field("out_consumed_count", want.consumed, out_consumed_count);
        end
      end
      if (in_valid && !in_stall) begin
        req = {in_priority_req, in_job_id, in_producer_number, in_process_id,
               in_compute_time};
        predicted = apply_request(mode_t'(in_mode), req);
        pending_results = {pending_results, predicted};
      end
    end
    outstanding <= pending_results.size();
    consumed_jobs <= consumed_total;
  end

endmodule

/* test/sorted_priority_job_queue_tb.sv */
// Testbench top for the sorted priority job queue: stimulus, stall patterns and verdict.
`timescale 1ns / 1ps

module sorted_priority_job_queue_tb;
  import spjq_pkg::*;

  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int LONG_HOLD_CYCLES = 200;
  localparam int DRAIN_CYCLES     = 4;
  localparam int PHASE_COUNT      = 8;
  localparam int PHASE_ITEMS      = 210;
  localparam int BURST_ITEMS      = 40;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_mode = 1'b0;
  logic [PRIO_W-1:0]   in_priority_req = '0;
  logic [JOB_ID_W-1:0] in_job_id = '0;
  logic [PROD_W-1:0]   in_producer_number = '0;
  logic [PID_W-1:0]    in_process_id = '0;
  logic [CTIME_W-1:0]  in_compute_time = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [PRIO_W-1:0]   out_priority;
  logic [JOB_ID_W-1:0] out_job_id;
  logic [PROD_W-1:0]   out_producer_number;
  logic [PID_W-1:0]    out_process_id;
  logic [CTIME_W-1:0]  out_compute_time;
  logic [OCC_W-1:0]    out_occupancy;
  logic [COUNT_W-1:0]  out_consumed_count;
  logic                cfg_we = 1'b0;
  logic [COUNT_W-1:0]  cfg_job_limit = LIMIT_RST;

  int                  fail_count;
  int                  outstanding;
  logic [COUNT_W-1:0]  consumed_jobs;
  bit                  hold_off_req = 1'b0;
  int                  idle_cycles = 0;

  always #5 clk = ~clk;

  sorted_priority_job_queue u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_priority_req    (in_priority_req),
    .in_job_id          (in_job_id),
    .in_producer_number (in_producer_number),
    .in_process_id      (in_process_id),
    .in_compute_time    (in_compute_time),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_priority       (out_priority),
    .out_job_id         (out_job_id),
    .out_producer_number(out_producer_number),
    .out_process_id     (out_process_id),
    .out_compute_time   (out_compute_time),
    .out_occupancy      (out_occupancy),
    .out_consumed_count (out_consumed_count),
    .cfg_we             (cfg_we),
    .cfg_job_limit      (cfg_job_limit)
  );

  spjq_job_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_priority_req    (in_priority_req),
    .in_job_id          (in_job_id),
    .in_producer_number (in_producer_number),
    .in_process_id      (in_process_id),
    .in_compute_time    (in_compute_time),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_priority       (out_priority),
    .out_job_id         (out_job_id),
    .out_producer_number(out_producer_number),
    .out_process_id     (out_process_id),
    .out_compute_time   (out_compute_time),
    .out_occupancy      (out_occupancy),
    .out_consumed_count (out_consumed_count),
    .cfg_we             (cfg_we),
    .cfg_job_limit      (cfg_job_limit),
    .fail_count         (fail_count),
    .outstanding        (outstanding),
    .consumed_jobs      (consumed_jobs)
  );

  function automatic job_t make_job(logic [PRIO_W-1:0] prio, logic [JOB_ID_W-1:0] id,
                                    logic [PROD_W-1:0] prod, logic [PID_W-1:0] pid,
                                    logic [CTIME_W-1:0] ctime);
    job_t j;
    j.prio = prio;
    j.job_id = id;
    j.producer = prod;
    j.pid = pid;
    j.ctime = ctime;
    return j;
  endfunction

  // Priorities cluster around tie_base so equal priorities meet often.
  function automatic job_t random_job(int tie_base);
    job_t j;
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) j.prio = '0;
    else if (r < 40) j.prio = PRIO_W'(tie_base + $urandom_range(0, 1));
    else j.prio = PRIO_W'($urandom_range(1, 15));
    j.job_id = JOB_ID_W'($urandom_range(0, 131071));
    j.producer = PROD_W'($urandom_range(0, 255));
    j.pid = PID_W'($urandom_range(0, 4194303));
    j.ctime = CTIME_W'($urandom_range(0, 15));
    return j;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  // Returns at the edge where the transaction is accepted; valid stays high.
  task automatic offer_job(mode_t mode, job_t job);
    in_mode <= mode;
    in_priority_req <= job.prio;
    in_job_id <= job.job_id;
    in_producer_number <= job.producer;
    in_process_id <= job.pid;
    in_compute_time <= job.ctime;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic idle_input(int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_job_limit(logic [COUNT_W-1:0] limit);
    wait_for_results();
    cfg_job_limit <= limit;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // No transaction on either side for too long means the block is hung.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("sorted_priority_job_queue regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : result_sink
    int r;
    int stretch;
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        stretch = LONG_HOLD_CYCLES;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          out_stall <= 1'b0;
          stretch = $urandom_range(1, 24);
        end else if (r < 93) begin
          out_stall <= 1'b1;
          stretch = $urandom_range(1, 4);
        end else begin
          out_stall <= 1'b1;
          stretch = $urandom_range(10, 40);
        end
      end
      repeat (stretch) @(posedge clk);
    end
  end

  initial begin : stimulus
    int phase;
    int n;
    int fill_bias;
    int tie_base;
    logic [COUNT_W-1:0] limit_val;
    mode_t mode;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // pop on an empty queue
    offer_job(MODE_POP, make_job('1, '1, '1, '1, '1));
    idle_input(pick_gap());
    // fill with ties, extremes, zero priority and zero compute time
    offer_job(MODE_INSERT, make_job(4'd5, '1, '1, '1, 4'd15));
    idle_input(pick_gap());
    offer_job(MODE_INSERT, make_job(4'd5, '0, '0, '0, 4'd0));
    idle_input(pick_gap());
    offer_job(MODE_INSERT, make_job(4'd15, '1, '1, '1, 4'd15));
    idle_input(pick_gap());
    offer_job(MODE_INSERT, make_job(4'd0, '0, '0, '0, 4'd0));
    idle_input(pick_gap());
    offer_job(MODE_INSERT, make_job(4'd1, 17'h0AAAA, 8'h55, 22'h2AAAAA, 4'd1));
    idle_input(pick_gap());
    offer_job(MODE_INSERT, make_job(4'd5, 17'h15555, 8'hAA, 22'h155555, 4'd10));
    idle_input(pick_gap());
    offer_job(MODE_INSERT, make_job(4'd10, 17'd1, 8'd1, 22'd1, 4'd7));
    idle_input(pick_gap());
    offer_job(MODE_INSERT, make_job(4'd1, 17'd2, 8'd2, 22'd2, 4'd8));
    idle_input(pick_gap());
    // queue is full now
    offer_job(MODE_INSERT, make_job(4'd15, 17'd3, 8'd3, 22'd3, 4'd3));
    idle_input(pick_gap());
    repeat (9) begin
      offer_job(MODE_POP, random_job(1));
      idle_input(pick_gap());
    end

    // zero limit refuses everything
    set_job_limit('0);
    offer_job(MODE_INSERT, make_job(4'd9, 17'd4, 8'd4, 22'd4, 4'd4));
    idle_input(pick_gap());
    offer_job(MODE_POP, random_job(1));
    idle_input(pick_gap());

    // limit reached in the middle of a sequence
    set_job_limit(consumed_jobs + COUNT_W'(2));
    offer_job(MODE_INSERT, make_job(4'd3, 17'd5, 8'd5, 22'd5, 4'd5));
    idle_input(pick_gap());
    offer_job(MODE_INSERT, make_job(4'd7, 17'd6, 8'd6, 22'd6, 4'd6));
    idle_input(pick_gap());
    repeat (3) begin
      offer_job(MODE_POP, random_job(1));
      idle_input(pick_gap());
    end

    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        2, 6:    limit_val = consumed_jobs + COUNT_W'($urandom_range(10, 60));
        3:       limit_val = COUNT_W'($urandom_range(0, 65535));
        4:       limit_val = consumed_jobs + COUNT_W'($urandom_range(1, 8));
        default: limit_val = COUNT_MAX;
      endcase
      set_job_limit(limit_val);

      if (phase == 1) begin
        // back-to-back traffic against a long result hold-off
        hold_off_req = 1'b1;
        repeat (BURST_ITEMS) begin
          mode = ($urandom_range(0, 99) < 60) ? MODE_INSERT : MODE_POP;
          offer_job(mode, random_job($urandom_range(1, 14)));
        end
        idle_input(1);
      end

      fill_bias = 50;
      tie_base = 1;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 30 == 0) begin
          case ($urandom_range(0, 3))
            0:       fill_bias = 80;
            1:       fill_bias = 20;
            2:       fill_bias = 50;
            default: fill_bias = $urandom_range(30, 70);
          endcase
          tie_base = $urandom_range(1, 14);
        end
        mode = ($urandom_range(0, 99) < fill_bias) ? MODE_INSERT : MODE_POP;
        offer_job(mode, random_job(tie_base));
        idle_input(pick_gap());
      end
    end

    wait_for_results();
    if (fail_count == 0 && outstanding == 0) begin
      $display("sorted_priority_job_queue regression: pass");
    end else begin
      $display("sorted_priority_job_queue regression: fail");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/spjq_pkg.sv
rtl/core/spjq_ctrl.sv
rtl/core/spjq_dpath.sv
rtl/core/sorted_priority_job_queue.sv
rtl/core/spjq_checker.sv
test/spjq_job_checker.sv
test/sorted_priority_job_queue_tb.sv
